@@ src/lcgja_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LCG jump-ahead package
// Shared types and constants for the LCG jump-ahead block.
// ----------------------------------------------------------------------------
package lcgja_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned BIT_CNT_W   = 5;

    localparam logic [CFG_INDEX_W-1:0] REG_MULTIPLIER = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INCREMENT  = 2'd1;

    localparam logic [WORD_W-1:0] RESET_MULTIPLIER = 32'h0003_43FD;
    localparam logic [WORD_W-1:0] RESET_INCREMENT  = 32'h0026_9EC3;

    localparam logic [BIT_CNT_W-1:0] LAST_BIT = 5'd31;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic out_hold;
    } dp_status_t;

endpackage : lcgja_pkg
`default_nettype wire

@@ src/lcgja_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LCG jump-ahead controller
// Sequences load, 32 doubling steps and the final affine map for each item.
// ----------------------------------------------------------------------------
module lcgja_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire lcgja_pkg::dp_status_t status,
    output lcgja_pkg::dp_cmd_t         cmd
);

    lcgja_pkg::state_t                  state_reg;
    lcgja_pkg::state_t                  state_next;
    logic [lcgja_pkg::BIT_CNT_W-1:0]    cnt_reg;
    logic [lcgja_pkg::BIT_CNT_W-1:0]    cnt_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lcgja_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = lcgja_pkg::ST_STEP;
                end
            end
            lcgja_pkg::ST_STEP:
            begin
                if (cnt_reg == lcgja_pkg::LAST_BIT)
                begin
                    state_next = lcgja_pkg::ST_FINISH;
                end
            end
            lcgja_pkg::ST_FINISH:
            begin
                if (!status.out_hold)
                begin
                    state_next = lcgja_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lcgja_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        cmd.finish = 1'b0;
        case (state_reg)
            lcgja_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            lcgja_pkg::ST_STEP:
            begin
                cmd.step = 1'b1;
            end
            lcgja_pkg::ST_FINISH:
            begin
                cmd.finish = !status.out_hold;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.load)
        begin
            cnt_next = '0;
        end
        else if (cmd.step)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcgja_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule : lcgja_ctrl
`default_nettype wire

@@ src/lcgja_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LCG jump-ahead datapath
// Configuration registers, doubling-step registers and the output register.
// ----------------------------------------------------------------------------
module lcgja_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [lcgja_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [lcgja_pkg::WORD_W-1:0]      cfg_data,
    input  wire logic [lcgja_pkg::WORD_W-1:0]      start_seed,
    input  wire logic [lcgja_pkg::WORD_W-1:0]      step_count,
    input  wire lcgja_pkg::dp_cmd_t                cmd,
    output lcgja_pkg::dp_status_t                  status,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [lcgja_pkg::WORD_W-1:0]           advanced_seed
);

    logic [lcgja_pkg::WORD_W-1:0] mult_reg;
    logic [lcgja_pkg::WORD_W-1:0] incr_reg;
    logic [lcgja_pkg::WORD_W-1:0] pow_mul_reg;
    logic [lcgja_pkg::WORD_W-1:0] pow_mul_next;
    logic [lcgja_pkg::WORD_W-1:0] pow_add_reg;
    logic [lcgja_pkg::WORD_W-1:0] pow_add_next;
    logic [lcgja_pkg::WORD_W-1:0] acc_mul_reg;
    logic [lcgja_pkg::WORD_W-1:0] acc_mul_next;
    logic [lcgja_pkg::WORD_W-1:0] acc_add_reg;
    logic [lcgja_pkg::WORD_W-1:0] acc_add_next;
    logic [lcgja_pkg::WORD_W-1:0] rest_reg;
    logic [lcgja_pkg::WORD_W-1:0] rest_next;
    logic [lcgja_pkg::WORD_W-1:0] seed_reg;
    logic [lcgja_pkg::WORD_W-1:0] seed_next;
    logic [lcgja_pkg::WORD_W-1:0] result_reg;
    logic [lcgja_pkg::WORD_W-1:0] result_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;

    logic [lcgja_pkg::WORD_W-1:0] acc_op;
    logic [lcgja_pkg::WORD_W-1:0] acc_prod;
    logic [lcgja_pkg::WORD_W-1:0] add_prod;
    logic [lcgja_pkg::WORD_W-1:0] pa_prod;
    logic [lcgja_pkg::WORD_W-1:0] sq_prod;

    // The accumulator multiplier is shared with the final seed * acc_mul.
    assign acc_op   = cmd.finish ? seed_reg : pow_mul_reg;
    assign acc_prod = acc_mul_reg * acc_op;
    assign add_prod = acc_add_reg * pow_mul_reg;
    assign pa_prod  = pow_add_reg * pow_mul_reg;
    assign sq_prod  = pow_mul_reg * pow_mul_reg;

    always_comb
    begin
        pow_mul_next = pow_mul_reg;
        pow_add_next = pow_add_reg;
        acc_mul_next = acc_mul_reg;
        acc_add_next = acc_add_reg;
        rest_next    = rest_reg;
        seed_next    = seed_reg;
        result_next  = result_reg;
        if (cmd.load)
        begin
            pow_mul_next = mult_reg;
            pow_add_next = incr_reg;
            acc_mul_next = {{(lcgja_pkg::WORD_W-1){1'b0}}, 1'b1};
            acc_add_next = '0;
            rest_next    = step_count;
            seed_next    = start_seed;
        end
        else if (cmd.step)
        begin
            if (rest_reg[0])
            begin
                acc_mul_next = acc_prod;
                acc_add_next = add_prod + pow_add_reg;
            end
            pow_add_next = pa_prod + pow_add_reg;
            pow_mul_next = sq_prod;
            rest_next    = {1'b0, rest_reg[lcgja_pkg::WORD_W-1:1]};
        end
        else if (cmd.finish)
        begin
            result_next = acc_prod + acc_add_reg;
        end
    end

    assign out_valid_next  = cmd.finish | (out_valid_reg & ~out_ready);
    assign status.out_hold = out_valid_reg & ~out_ready;
    assign out_valid       = out_valid_reg;
    assign advanced_seed   = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg      <= lcgja_pkg::RESET_MULTIPLIER;
            incr_reg      <= lcgja_pkg::RESET_INCREMENT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_write && (cfg_index == lcgja_pkg::REG_MULTIPLIER))
            begin
                mult_reg <= cfg_data;
            end
            if (cfg_write && (cfg_index == lcgja_pkg::REG_INCREMENT))
            begin
                incr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pow_mul_reg <= pow_mul_next;
        pow_add_reg <= pow_add_next;
        acc_mul_reg <= acc_mul_next;
        acc_add_reg <= acc_add_next;
        rest_reg    <= rest_next;
        seed_reg    <= seed_next;
        result_reg  <= result_next;
    end

endmodule : lcgja_datapath
`default_nettype wire

@@ src/lcg_jump_ahead.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LCG jump-ahead
// Advances a 32-bit linear congruential generator state by a step count.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_ready    start_seed, step_count
// out       output     out_valid/out_ready  advanced_seed
// cfg       input      cfg_write            cfg_index, cfg_data
//
// An item is loaded at the accepting edge, then runs one doubling step per step-count
// bit (32) and then the final map before its result is valid. The block works on one
// transaction at a time and takes no new one before its result is registered.
// The doubling loop handles one step-count bit per cycle.
// A new transaction is accepted as soon as the result is in the output register.
// A stalled result holds the block in its final cycle until the register frees.
// Reset restores the multiplier and increment registers to their defaults.
// ----------------------------------------------------------------------------
module lcg_jump_ahead (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [lcgja_pkg::WORD_W-1:0]      start_seed,
    input  wire logic [lcgja_pkg::WORD_W-1:0]      step_count,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [lcgja_pkg::WORD_W-1:0]           advanced_seed,
    input  wire logic                              cfg_write,
    input  wire logic [lcgja_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [lcgja_pkg::WORD_W-1:0]      cfg_data
);

    lcgja_pkg::dp_cmd_t    cmd;
    lcgja_pkg::dp_status_t status;

    lcgja_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lcgja_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .start_seed    (start_seed),
        .step_count    (step_count),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .advanced_seed (advanced_seed)
    );

endmodule : lcg_jump_ahead
`default_nettype wire

@@ src/lcgja_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LCG jump-ahead checker
// Port-level assertions on the top level, attached by bind.
// ----------------------------------------------------------------------------
module lcgja_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_ready,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic [lcgja_pkg::WORD_W-1:0] advanced_seed
);

    // A stalled result stays valid and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(advanced_seed)))
        else $error("stalled result changed or dropped");

    // Only one transaction is in work at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while busy");

    // No result appears in the cycle right after an input transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !out_valid) |=> !out_valid)
        else $error("result appeared too early");

    // A new result leaves the block ready for the next transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("block not ready after producing a result");

endmodule : lcgja_checker

bind lcg_jump_ahead lcgja_checker u_lcgja_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .advanced_seed (advanced_seed)
);
`default_nettype wire

@@ sim/lcg_jump_ahead_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCG jump-ahead regression
// Drives seed and step-count transactions into the jump-ahead block under
// several multiplier and increment settings, with random idling on both
// channels, and compares every advanced seed against a square-and-sum
// prediction kept in a small scoreboard.
// ----------------------------------------------------------------------------
module lcg_jump_ahead_test;

    localparam logic [lcgja_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [lcgja_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;
    localparam int IDLE_PCT       = 34;
    localparam int PHASES         = 10;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 400;

    class jump_tracker;
        logic [lcgja_pkg::WORD_W-1:0] mult_reg;
        logic [lcgja_pkg::WORD_W-1:0] inc_reg;
        logic [lcgja_pkg::WORD_W-1:0] advanced_seeds[$];
        int errors;

        function new();
            mult_reg = lcgja_pkg::RESET_MULTIPLIER;
            inc_reg  = lcgja_pkg::RESET_INCREMENT;
            errors   = 0;
        endfunction

        function void set_register(logic [lcgja_pkg::CFG_INDEX_W-1:0] index,
                                   logic [lcgja_pkg::WORD_W-1:0] data);
            case (index)
                lcgja_pkg::REG_MULTIPLIER: mult_reg = data;
                lcgja_pkg::REG_INCREMENT:  inc_reg  = data;
                default: ;
            endcase
        endfunction

        function logic [lcgja_pkg::WORD_W-1:0] skip_ahead(
            logic [lcgja_pkg::WORD_W-1:0] seed,
            logic [lcgja_pkg::WORD_W-1:0] steps);
            logic [lcgja_pkg::WORD_W-1:0] pow_mul;
            logic [lcgja_pkg::WORD_W-1:0] pow_add;
            logic [lcgja_pkg::WORD_W-1:0] total_mul;
            logic [lcgja_pkg::WORD_W-1:0] total_add;
            pow_mul   = mult_reg;
            pow_add   = inc_reg;
            total_mul = 32'd1;
            total_add = 32'd0;
            for (int i = 0; i < lcgja_pkg::WORD_W; i++)
            begin
                if (steps[i])
                begin
                    total_mul = total_mul * pow_mul;
                    total_add = total_add * pow_mul + pow_add;
                end
                pow_add = pow_add * (pow_mul + 32'd1);
                pow_mul = pow_mul * pow_mul;
            end
            return seed * total_mul + total_add;
        endfunction

        function void note_input(logic [lcgja_pkg::WORD_W-1:0] seed,
                                 logic [lcgja_pkg::WORD_W-1:0] steps);
            advanced_seeds = {advanced_seeds, skip_ahead(seed, steps)};
        endfunction

        function void check_result(logic [lcgja_pkg::WORD_W-1:0] actual);
            logic [lcgja_pkg::WORD_W-1:0] predicted;
            if (advanced_seeds.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected advanced_seed %08h with nothing outstanding", actual);
                return;
            end
            predicted = advanced_seeds.pop_front();
            if (actual !== predicted)
            begin
                errors++;
                if (errors <= 10)
                    $display("advanced_seed mismatch: expected %08h, actual %08h",
                             predicted, actual);
            end
        endfunction

        function int outstanding();
            return advanced_seeds.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [lcgja_pkg::WORD_W-1:0] start_seed = '0;
    logic [lcgja_pkg::WORD_W-1:0] step_count = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [lcgja_pkg::WORD_W-1:0] advanced_seed;
    logic cfg_write = 1'b0;
    logic [lcgja_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [lcgja_pkg::WORD_W-1:0] cfg_data = '0;

    logic steady = 1'b0;
    logic hold_request = 1'b0;
    jump_tracker tracker = new();

    logic [lcgja_pkg::WORD_W-1:0] corner_seeds[16] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678, 32'h0000_0000,
        32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_A5A5,
        32'h5A5A_5A5A, 32'h0000_0001, 32'hDEAD_BEEF, 32'h0000_0000,
        32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hCAFE_F00D
    };
    logic [lcgja_pkg::WORD_W-1:0] corner_steps[16] = '{
        32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001,
        32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
        32'h7FFF_FFFF, 32'h0000_0002, 32'h0000_0003, 32'h5555_5555,
        32'hAAAA_AAAA, 32'h0000_0020, 32'h0001_0000, 32'hFFFF_FFFE
    };
    logic [lcgja_pkg::WORD_W-1:0] fixed_mult[6] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
        lcgja_pkg::RESET_MULTIPLIER, 32'hFFFF_FFFF, 32'h0000_0000
    };
    logic [lcgja_pkg::WORD_W-1:0] fixed_inc[6] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
        lcgja_pkg::RESET_INCREMENT, 32'h0000_0000, 32'hFFFF_FFFF
    };

    lcg_jump_ahead dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .start_seed    (start_seed),
        .step_count    (step_count),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .advanced_seed (advanced_seed),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic logic [lcgja_pkg::WORD_W-1:0] pick_steps();
        logic [lcgja_pkg::WORD_W-1:0] r;
        r = $urandom();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return $urandom_range(1, 64);
            2: return 32'h1 << $urandom_range(0, 31);
            3: return ~$urandom_range(0, 15);
            4: return r >> $urandom_range(0, 31);
            default: return r;
        endcase
    endfunction

    function automatic logic [lcgja_pkg::WORD_W-1:0] pick_seed();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_item(logic [lcgja_pkg::WORD_W-1:0] seed,
                             logic [lcgja_pkg::WORD_W-1:0] steps);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        start_seed <= seed;
        step_count <= steps;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.note_input(seed, steps);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic program_register(logic [lcgja_pkg::CFG_INDEX_W-1:0] index,
                                    logic [lcgja_pkg::WORD_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        tracker.set_register(index, data);
        @(posedge clk);
    endtask

    initial
    begin : receiver
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
            end
            out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            @(posedge clk);
            if (out_valid && out_ready)
                tracker.check_result(advanced_seed);
        end
    end

    initial
    begin : watchdog
        #4_000_000;
        $display("lcg_jump_ahead regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        logic [lcgja_pkg::WORD_W-1:0] mult_value;
        logic [lcgja_pkg::WORD_W-1:0] inc_value;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < 16; k++)
            send_item(corner_seeds[k], corner_steps[k]);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain();
            repeat (SETTLE_CYCLES)
                @(posedge clk);
            if (phase < 6)
            begin
                mult_value = fixed_mult[phase];
                inc_value  = fixed_inc[phase];
            end
            else if (phase % 2 == 0)
            begin
                mult_value = ($urandom() & 32'hFFFF_FFFC) | 32'h1;
                inc_value  = $urandom() | 32'h1;
            end
            else
            begin
                mult_value = $urandom();
                inc_value  = $urandom();
            end
            program_register(lcgja_pkg::REG_MULTIPLIER, mult_value);
            program_register(lcgja_pkg::REG_INCREMENT, inc_value);
            if (phase == 3)
            begin
                program_register(REG_SPARE_LO, $urandom());
                program_register(REG_SPARE_HI, $urandom());
            end
            steady = (phase == 5);
            if (phase == 2)
                hold_request = 1'b1;

            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (phase == 7 && k == ITEMS_PER_PHASE / 2)
                    drain();
                send_item(pick_seed(), pick_steps());
            end
        end

        drain();
        steady = 1'b0;
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (tracker.errors == 0 && tracker.outstanding() == 0)
            $display("lcg_jump_ahead regression: pass");
        else
            $display("lcg_jump_ahead regression: fail");
        $finish;
    end

endmodule
